// ===== hdl/srpc_pkg.sv =====
package srpc_pkg;

    // Default sizes
    localparam int MAX_VALUE_DEF   = 100000;
    localparam int TABLE_DEPTH_DEF = 1024;

    // Field widths
    localparam int ENTRY_INDEX_W = 10;
    localparam int ENTRY_VALUE_W = 17;
    localparam int QUERY_W       = 32;
    localparam int COUNT_W       = 11;
    localparam int ENTRY_COUNT_W = 11;

    // Configuration port
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_ENTRY_COUNT = 2'd0;
    localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RESET = 11'd1;

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_FILL,
        S_CHECK,
        S_TEST,
        S_MARK,
        S_NEXT,
        S_DONE
    } t_sieve_state;

    typedef enum logic [3:0] {
        Q_IDLE,
        Q_START,
        Q_RD0,
        Q_RDN,
        Q_ENDS,
        Q_MID,
        Q_CMP,
        Q_FIN,
        Q_SETUP,
        Q_WALK,
        Q_DRAIN,
        Q_OUT
    } t_query_state;

endpackage

// ===== hdl/srpc_ram.sv =====
module srpc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/srpc_sieve.sv =====
module srpc_sieve #(
    parameter int MAX_VALUE = srpc_pkg::MAX_VALUE_DEF,
    localparam int BW = $clog2(MAX_VALUE + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    output logic          o_done,
    output logic          o_we,
    output logic [BW-1:0] o_waddr,
    output logic          o_wdata,
    output logic [BW-1:0] o_raddr,
    input  logic          i_rdata
);
    import srpc_pkg::*;

    localparam int MW = BW + 1;

    t_sieve_state r_state, n_state;
    logic [BW-1:0] r_fill;
    logic [BW-1:0] r_base;
    logic [MW-1:0] r_sq;
    logic [MW-1:0] r_mult;
    logic          mult_over;

    assign mult_over = r_mult > MW'(MAX_VALUE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_FILL:  if (r_fill == BW'(MAX_VALUE)) n_state = S_CHECK;
            S_CHECK: n_state = (r_sq > MW'(MAX_VALUE)) ? S_DONE : S_TEST;
            S_TEST:  n_state = i_rdata ? S_MARK : S_NEXT;
            S_MARK:  if (mult_over) n_state = S_NEXT;
            S_NEXT:  n_state = S_CHECK;
            S_DONE:  n_state = S_DONE;
            default: n_state = S_FILL;
        endcase
    end

    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_fill;
        o_wdata = 1'b0;
        o_raddr = r_base;
        o_done  = 1'b0;
        unique case (r_state)
            S_FILL: begin
                o_we    = 1'b1;
                o_waddr = r_fill;
                o_wdata = r_fill >= BW'(2);
            end
            S_MARK: begin
                o_we    = !mult_over;
                o_waddr = r_mult[BW-1:0];
            end
            S_DONE:  o_done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_fill  <= '0;
            r_base  <= BW'(2);
            r_sq    <= MW'(4);
            r_mult  <= MW'(4);
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_FILL: r_fill <= r_fill + BW'(1);
                S_TEST: r_mult <= r_sq;
                S_MARK: r_mult <= r_mult + MW'(r_base);
                S_NEXT: begin
                    // (b+1)^2 = b^2 + 2b + 1
                    r_base <= r_base + BW'(1);
                    r_sq   <= r_sq + {r_base, 1'b1};
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/srpc_query.sv =====
module srpc_query #(
    parameter int MAX_VALUE   = srpc_pkg::MAX_VALUE_DEF,
    parameter int TABLE_DEPTH = srpc_pkg::TABLE_DEPTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int BW = $clog2(MAX_VALUE + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [srpc_pkg::ENTRY_COUNT_W-1:0]  i_entry_count,
    input  logic signed [srpc_pkg::QUERY_W-1:0] i_low,
    input  logic signed [srpc_pkg::QUERY_W-1:0] i_high,
    output logic                                o_busy,
    output logic                                o_done,
    output logic [srpc_pkg::COUNT_W-1:0]        o_count,
    output logic [AW-1:0]                       o_tbl_raddr,
    input  logic [srpc_pkg::ENTRY_VALUE_W-1:0]  i_tbl_rdata,
    output logic [BW-1:0]                       o_bm_raddr,
    input  logic                                i_bm_rdata
);
    import srpc_pkg::*;

    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = QUERY_W + 1;

    t_query_state r_state, n_state;

    logic signed [QUERY_W-1:0] r_low, r_high;
    logic [NW-1:0]  r_n, n_sat;
    logic           r_side;        // 0: first match of low, 1: last match of high
    logic [AW-1:0]  r_lo, r_hi, r_mid, r_lpos, r_rpos, r_walk;
    logic           r_below, r_eq0;
    logic           r_v1, r_v2, r_inr;
    logic [COUNT_W-1:0] r_count;

    logic [AW-1:0]  last_pos, mid;
    logic [AW:0]    mid_sum;
    logic           span_open;
    logic signed [CW-1:0] cmp_a, cmp_b;
    logic           cmp_lt, cmp_eq, cmp_gt;
    logic [31:0]    val32;

    assign n_sat = (32'(i_entry_count) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(i_entry_count);
    assign last_pos  = AW'(r_n - NW'(1));
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = mid_sum[AW:1];
    assign span_open = {1'b0, r_hi} > ({1'b0, r_lo} + (AW+1)'(1));

    // shared compare unit: bound ordering first, then table word against key
    always_comb begin
        if (r_state == Q_START) begin
            cmp_a = CW'(r_low);
            cmp_b = CW'(r_high);
        end else begin
            cmp_a = signed'(CW'(i_tbl_rdata));
            cmp_b = r_side ? CW'(r_high) : CW'(r_low);
        end
    end
    assign cmp_lt = cmp_a < cmp_b;
    assign cmp_eq = cmp_a == cmp_b;
    assign cmp_gt = !cmp_lt && !cmp_eq;

    assign val32      = 32'(i_tbl_rdata);
    assign o_bm_raddr = val32[BW-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            Q_IDLE:  if (i_start) n_state = Q_START;
            Q_START: n_state = (r_n == '0 || cmp_gt) ? Q_OUT : Q_RD0;
            Q_RD0:   n_state = Q_RDN;
            Q_RDN:   n_state = Q_ENDS;
            Q_ENDS: begin
                if (r_below || cmp_lt) begin
                    n_state = Q_OUT;
                end else if (!r_side && r_eq0) begin
                    n_state = Q_RD0;
                end else if (r_side && cmp_eq) begin
                    n_state = Q_SETUP;
                end else begin
                    n_state = Q_MID;
                end
            end
            Q_MID:   n_state = span_open ? Q_CMP : Q_FIN;
            Q_CMP:   n_state = Q_MID;
            Q_FIN: begin
                if (!cmp_eq) begin
                    n_state = Q_OUT;
                end else begin
                    n_state = r_side ? Q_SETUP : Q_RD0;
                end
            end
            Q_SETUP: n_state = (r_lpos > r_rpos) ? Q_OUT : Q_WALK;
            Q_WALK:  if (r_walk == r_rpos) n_state = Q_DRAIN;
            Q_DRAIN: if (!r_v1 && !r_v2) n_state = Q_OUT;
            Q_OUT:   n_state = Q_IDLE;
            default: n_state = Q_IDLE;
        endcase
    end

    always_comb begin
        o_tbl_raddr = '0;
        unique case (r_state)
            Q_RDN:   o_tbl_raddr = last_pos;
            Q_MID:   o_tbl_raddr = span_open ? mid : (r_side ? r_lo : r_hi);
            Q_WALK:  o_tbl_raddr = r_walk;
            default: o_tbl_raddr = '0;
        endcase
    end

    assign o_busy  = r_state != Q_IDLE;
    assign o_done  = r_state == Q_OUT;
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_side  <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= r_state == Q_WALK;
            r_v2    <= r_v1;
            unique case (r_state)
                Q_IDLE: begin
                    if (i_start) begin
                        r_low   <= i_low;
                        r_high  <= i_high;
                        r_n     <= n_sat;
                        r_side  <= 1'b0;
                        r_count <= '0;
                    end
                end
                Q_RDN: begin
                    r_below <= cmp_gt;
                    r_eq0   <= cmp_eq;
                end
                Q_ENDS: begin
                    r_lo <= '0;
                    r_hi <= last_pos;
                    if (!r_side && r_eq0) begin
                        r_lpos <= '0;
                        r_side <= 1'b1;
                    end
                    if (r_side && cmp_eq) begin
                        r_rpos <= last_pos;
                    end
                end
                Q_MID: r_mid <= mid;
                Q_CMP: begin
                    if (!r_side) begin
                        if (cmp_lt) r_lo <= r_mid;
                        else        r_hi <= r_mid;
                    end else begin
                        if (cmp_gt) r_hi <= r_mid;
                        else        r_lo <= r_mid;
                    end
                end
                Q_FIN: begin
                    if (cmp_eq) begin
                        if (!r_side) begin
                            r_lpos <= r_hi;
                            r_side <= 1'b1;
                        end else begin
                            r_rpos <= r_lo;
                        end
                    end
                end
                Q_SETUP: r_walk <= r_lpos;
                Q_WALK:  r_walk <= r_walk + AW'(1);
                default: ;
            endcase
            // count walk: table word, then bitmap bit
            r_inr <= val32 <= 32'(MAX_VALUE);
            if (r_v2 && r_inr && i_bm_rdata) begin
                r_count <= r_count + COUNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/sorted_range_prime_counter.sv =====
// Channel  | Direction | Handshake                 | Word
// ---------+-----------+---------------------------+-------------------------------------------
// command  | in        | start & !busy             | i_cmd, i_entry_index, i_entry_value,
//          |           |                           | i_query_low, i_query_high
// result   | out       | o_done, one cycle         | o_prime_count
// config   | in/out    | psel & penable & pwrite   | paddr, pwdata, prdata (entry_count @ 0)
//
// After reset busy stays high while the prime bitmap is built: a fill pass over all MAX_VALUE+1
// entries, then each base up to the square root of MAX_VALUE is read and, if prime, its multiples
// from its square upward are marked. A query orders the bounds, runs two binary searches on the
// single table read port, opens the walk, walks the counted span, drains the count pipeline and
// presents the result word.
// Reset is synchronous, active low. The receiver cannot stall: o_done lasts one cycle.
module sorted_range_prime_counter #(
    parameter int MAX_VALUE   = srpc_pkg::MAX_VALUE_DEF,
    parameter int TABLE_DEPTH = srpc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    i_cmd,
    input  logic [srpc_pkg::ENTRY_INDEX_W-1:0]      i_entry_index,
    input  logic [srpc_pkg::ENTRY_VALUE_W-1:0]      i_entry_value,
    input  logic signed [srpc_pkg::QUERY_W-1:0]     i_query_low,
    input  logic signed [srpc_pkg::QUERY_W-1:0]     i_query_high,
    output logic                                    o_done,
    output logic [srpc_pkg::COUNT_W-1:0]            o_prime_count,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [srpc_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [srpc_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [srpc_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);
    import srpc_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BW = $clog2(MAX_VALUE + 1);

    logic [ENTRY_COUNT_W-1:0] r_entry_count;
    logic                     accept, q_start, q_busy, tbl_we;
    logic [31:0]              idx32;
    logic [AW-1:0]            tbl_raddr;
    logic [ENTRY_VALUE_W-1:0] tbl_rdata;
    logic                     sieve_done, s_we, s_wdata, bm_rdata;
    logic [BW-1:0]            s_waddr, s_raddr, q_bm_raddr, bm_raddr;

    // configuration
    assign pready = 1'b1;
    assign prdata = APB_DATA_W'(r_entry_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= ENTRY_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_ENTRY_COUNT) begin
            r_entry_count <= pwdata[ENTRY_COUNT_W-1:0];
        end
    end

    assign busy    = !sieve_done || q_busy;
    assign accept  = start && !busy;
    assign q_start = accept && i_cmd == CMD_QUERY;
    assign idx32   = 32'(i_entry_index);
    assign tbl_we  = accept && i_cmd == CMD_LOAD && idx32 < 32'(TABLE_DEPTH);

    srpc_ram #(
        .WIDTH (ENTRY_VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (idx32[AW-1:0]),
        .i_wdata (i_entry_value),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    srpc_sieve #(
        .MAX_VALUE (MAX_VALUE)
    ) u_sieve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_done  (sieve_done),
        .o_we    (s_we),
        .o_waddr (s_waddr),
        .o_wdata (s_wdata),
        .o_raddr (s_raddr),
        .i_rdata (bm_rdata)
    );

    // bitmap read port belongs to the sieve until it finishes
    assign bm_raddr = sieve_done ? q_bm_raddr : s_raddr;

    srpc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_VALUE + 1)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    srpc_query #(
        .MAX_VALUE   (MAX_VALUE),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_query (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (q_start),
        .i_entry_count (r_entry_count),
        .i_low         (i_query_low),
        .i_high        (i_query_high),
        .o_busy        (q_busy),
        .o_done        (o_done),
        .o_count       (o_prime_count),
        .o_tbl_raddr   (tbl_raddr),
        .i_tbl_rdata   (tbl_rdata),
        .o_bm_raddr    (q_bm_raddr),
        .i_bm_rdata    (bm_rdata)
    );

    a_done_needs_sieve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> sieve_done)
        else $error("result word before bitmap was built");

    a_bitmap_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sieve_done |-> !s_we)
        else $error("bitmap written after sieve finished");

    a_query_holds_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_start |=> busy && !o_done)
        else $error("query did not hold off the command port");

    a_done_ends_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !q_busy)
        else $error("query engine still busy after result word");

endmodule
